// ----- sv/u2da_pkg.sv -----
// ----------------------------------------------------------------------------
// u2da_pkg
// Shared widths, constants and types for the binary to decimal ASCII
// formatter: digit layout of the BCD word and the stage-to-stage word.
// ----------------------------------------------------------------------------
package u2da_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned NUM_DIGITS     = 10;
  localparam int unsigned BCD_W          = NUM_DIGITS * DIGIT_W;
  localparam int unsigned CHAR_W         = 6;
  localparam int unsigned NUM_STAGES     = 4;
  localparam int unsigned BITS_PER_STAGE = VALUE_W / NUM_STAGES;
  localparam int unsigned IDX_W          = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = DIGIT_W'(3);

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  // Word carried down the conversion pipeline: BCD digits and remaining bits
  typedef struct packed {
    bcd_t               bcd;
    logic [VALUE_W-1:0] bin;
  } conv_word_t;

endpackage

// ----- sv/u2da_dabble_stage.sv -----
// ----------------------------------------------------------------------------
// u2da_dabble_stage
// One pipeline stage of the shift-and-add-3 conversion: runs a fixed slice
// of binary bits into the BCD digits and registers the result.
// ----------------------------------------------------------------------------
module u2da_dabble_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  u2da_pkg::conv_word_t word_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output u2da_pkg::conv_word_t word_o
);
  import u2da_pkg::*;

  logic       valid_q;
  conv_word_t word_q;
  conv_word_t word_d;
  logic       load;

  // Shift one bit per step, correcting digits of five or more beforehand
  always_comb begin
    word_d = word_i;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (word_d.bcd[d] >= ADJ_LIMIT) begin
          word_d.bcd[d] = word_d.bcd[d] + ADJ_ADD;
        end
      end
      word_d = conv_word_t'({word_d, 1'b0} >> 0);
    end
  end

  // Hold while the next stage stalls a valid word
  assign stall_o = valid_q && stall_i;
  assign load    = valid_i && !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ----- sv/u2da_serializer.sv -----
// ----------------------------------------------------------------------------
// u2da_serializer
// Takes a finished BCD word and sends its digits as ASCII characters, most
// significant nonzero digit first, one at a time into an output register.
// ----------------------------------------------------------------------------
module u2da_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  u2da_pkg::bcd_t                bcd_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [u2da_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                          last_o
);
  import u2da_pkg::*;

  logic              busy_q;
  logic [IDX_W-1:0]  idx_q;
  bcd_t              bcd_q;
  logic              out_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic [IDX_W-1:0]  top_idx;
  logic              out_free;
  logic              emit;
  logic              emit_last;
  logic              load;

  // Find the most significant nonzero digit; zero keeps digit 0
  always_comb begin
    top_idx = '0;
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (bcd_i[d] != '0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  assign out_free  = !out_valid_q || !stall_i;
  assign emit      = busy_q && out_free;
  assign emit_last = emit && (idx_q == '0);
  assign stall_o   = busy_q && !emit_last;
  assign load      = valid_i && !stall_o;

  // Advance the digit index; load a new word when idle or on the final digit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= top_idx;
      end else if (emit_last) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q - IDX_W'(1);
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q <= bcd_i;
    end
    if (emit) begin
      char_q <= ASCII_ZERO + CHAR_W'(bcd_q[idx_q]);
      last_q <= (idx_q == '0);
    end
  end

  assign valid_o      = out_valid_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

endmodule

// ----- sv/uint32_to_decimal_ascii.sv -----
// The serializer sends one character per digit of a word (1 to 10), one per
// cycle unless out_stall_i holds it; the four conversion stages take a word
// every cycle unless stalled. Reset clears all valid and busy flags.
// ----------------------------------------------------------------------------
// uint32_to_decimal_ascii
// Formats a 32-bit unsigned value as decimal ASCII characters without leading
// zeros, marking the last character. Pipelined shift-and-add-3 conversion.
// ----------------------------------------------------------------------------
module uint32_to_decimal_ascii (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [u2da_pkg::VALUE_W-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [u2da_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                          last_o
);
  import u2da_pkg::*;

  logic       valid_s [NUM_STAGES+1];
  logic       stall_s [NUM_STAGES+1];
  conv_word_t word_s  [NUM_STAGES+1];

  // Start each word with empty BCD digits
  assign valid_s[0]     = in_valid_i;
  assign word_s[0].bcd  = '0;
  assign word_s[0].bin  = value_i;
  assign in_stall_o     = stall_s[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    u2da_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[g]),
      .stall_o (stall_s[g]),
      .word_i  (word_s[g]),
      .valid_o (valid_s[g+1]),
      .stall_i (stall_s[g+1]),
      .word_o  (word_s[g+1])
    );
  end

  u2da_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_s[NUM_STAGES]),
    .stall_o      (stall_s[NUM_STAGES]),
    .bcd_i        (word_s[NUM_STAGES].bcd),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

endmodule
